FILE: src/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and constants for the rotating queue with expedite.
// ----------------------------------------------------------------------------
package rrq_pkg;

	localparam int unsigned DEF_QUEUE_DEPTH = 64;
	localparam int unsigned ID_W            = 32;

	localparam logic [1:0] OP_SERVE    = 2'd0;
	localparam logic [1:0] OP_EXPEDITE = 2'd1;
	localparam logic [1:0] OP_RESTART  = 2'd2;

	typedef struct packed {
		logic [1:0]      opcode;
		logic [ID_W-1:0] member_id;
	} rrq_in_t;

	typedef struct packed {
		logic [ID_W-1:0] served_id;
		logic            queue_empty;
	} rrq_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SERVE_RD,
		ST_SERVE_WB,
		ST_EXP_WALK,
		ST_EXP_PUT,
		ST_FILL
	} rrq_state_t;

endpackage

FILE: src/rrq_ram.sv
// ----------------------------------------------------------------------------
// rrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/rrq_ctrl.sv
// ----------------------------------------------------------------------------
// rrq_ctrl
// Sequencer for the circular queue: serve, expedite walk and restart fill.
// ----------------------------------------------------------------------------
module rrq_ctrl import rrq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	localparam int unsigned AW = $clog2(QUEUE_DEPTH),
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rrq_in_t         in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output rrq_out_t        out_data,
	input  logic            cfg_wr_en,
	input  logic [ID_W-1:0] cfg_wr_data,
	output logic            ram_we,
	output logic [AW-1:0]   ram_waddr,
	output logic [ID_W-1:0] ram_wdata,
	output logic            ram_re,
	output logic [AW-1:0]   ram_raddr,
	input  logic [ID_W-1:0] ram_rdata,
	output logic [CW-1:0]   occupancy
);

	localparam logic [CW:0]   DEPTH_X = (CW+1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

	rrq_state_t      state_q, state_d;
	logic [AW-1:0]   head_q, head_d;
	logic [CW-1:0]   occ_q, occ_d;
	logic [CW-1:0]   rd_q, rd_d;
	logic [CW-1:0]   wr_q, wr_d;
	logic [CW-1:0]   lim_q, lim_d;
	logic            s1_valid_s1, s1_valid_d;
	logic [ID_W-1:0] who_q, who_d;
	logic [ID_W-1:0] pop_q;
	logic            out_valid_q, out_load;
	rrq_out_t        out_q, out_d;
	logic            out_free;
	logic [CW-1:0]   fill_n;
	logic [CW-1:0]   wr_cap;

	function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[AW-1:0];
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign fill_n    = (pop_q > ID_W'(QUEUE_DEPTH)) ? DEPTH_C : pop_q[CW-1:0];
	assign wr_cap    = (wr_q >= DEPTH_C) ? DEPTH_C - 1'b1 : wr_q;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign occupancy = occ_q;

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		occ_d      = occ_q;
		rd_d       = rd_q;
		wr_d       = wr_q;
		lim_d      = lim_q;
		who_d      = who_q;
		s1_valid_d = 1'b0;
		out_load   = 1'b0;
		out_d      = out_q;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.opcode)
						OP_SERVE: begin
							state_d = ST_SERVE_RD;
						end
						OP_EXPEDITE: begin
							who_d   = in_data.member_id;
							rd_d    = '0;
							wr_d    = '0;
							state_d = ST_EXP_WALK;
						end
						OP_RESTART: begin
							head_d = '0;
							wr_d   = '0;
							lim_d  = fill_n;
							if (fill_n == '0) begin
								occ_d = '0;
							end else begin
								state_d = ST_FILL;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SERVE_RD: begin
				if (occ_q == '0) begin
					if (out_free) begin
						out_load          = 1'b1;
						out_d.served_id   = '0;
						out_d.queue_empty = 1'b1;
						state_d           = ST_IDLE;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = head_q;
					state_d   = ST_SERVE_WB;
				end
			end
			ST_SERVE_WB: begin
				if (out_free) begin
					out_load          = 1'b1;
					out_d.served_id   = ram_rdata;
					out_d.queue_empty = 1'b0;
					ram_we            = 1'b1;
					ram_waddr         = wrap_idx(head_q, occ_q);
					ram_wdata         = ram_rdata;
					head_d            = (head_q == LAST_A) ? '0 : head_q + 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_EXP_WALK: begin
				// compact in place: writes trail the reads
				if (rd_q < occ_q) begin
					ram_re     = 1'b1;
					ram_raddr  = wrap_idx(head_q, rd_q);
					rd_d       = rd_q + 1'b1;
					s1_valid_d = 1'b1;
				end
				if (s1_valid_s1 && ram_rdata != who_q) begin
					ram_we    = 1'b1;
					ram_waddr = wrap_idx(head_q, wr_q);
					ram_wdata = ram_rdata;
					wr_d      = wr_q + 1'b1;
				end
				if (rd_q == occ_q && !s1_valid_s1) begin
					state_d = ST_EXP_PUT;
				end
			end
			ST_EXP_PUT: begin
				// new front sits just ahead of the old one, over a dropped tail if full
				head_d    = (head_q == '0) ? LAST_A : head_q - 1'b1;
				ram_we    = 1'b1;
				ram_waddr = head_d;
				ram_wdata = who_q;
				occ_d     = wr_cap + 1'b1;
				state_d   = ST_IDLE;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = wr_q[AW-1:0];
				ram_wdata = ID_W'(wr_q) + 1'b1;
				wr_d      = wr_q + 1'b1;
				if (wr_d == lim_q) begin
					occ_d   = lim_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			lim_q       <= '0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			pop_q       <= '0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			occ_q       <= occ_d;
			rd_q        <= rd_d;
			wr_q        <= wr_d;
			lim_q       <= lim_d;
			s1_valid_s1 <= s1_valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				pop_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		who_q <= who_d;
		out_q <= out_d;
	end

endmodule

FILE: src/rotating_queue_with_expedite_top.sv
// ----------------------------------------------------------------------------
// rotating_queue_with_expedite_top
// Round-robin member queue with move-to-front, held in one RAM.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall / in_data, one command per transfer
//   (serve, expedite, restart). out channel: out_valid / out_stall /
//   out_data, one result per serve. cfg_wr_en / cfg_wr_data set population.
//   the queue is a circular buffer in the RAM with a head pointer and count;
//   every RAM access goes through the single RAM port pair.
//   steps per command, from the transfer until the next one can be taken:
//     serve     a RAM read, then write back and load the result register;
//               only the result register load when the queue is empty
//     expedite  one RAM read per entry, a step to drain the last read,
//               then the insert
//     restart   one write per entry, min(population, QUEUE_DEPTH) entries
//   in_stall is high while a command is in progress.
//   the result register frees the input side; a serve that finds it still
//   full and stalled waits in place until the waiting result transfers.
//   reset empties the queue and clears population; RAM contents are not
//   cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
module rotating_queue_with_expedite_top import rrq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rrq_in_t         in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output rrq_out_t        out_data,
	input  logic            cfg_wr_en,
	input  logic [ID_W-1:0] cfg_wr_data
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [ID_W-1:0] ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [ID_W-1:0] ram_rdata;
	logic [CW-1:0]   occupancy;

	rrq_ram #(
		.WIDTH(ID_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rrq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.occupancy  (occupancy)
	);

	// compaction never writes the entry being read
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("ram read and write hit the same entry");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= CW'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_serve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.opcode == OP_SERVE |=> in_stall)
		else $error("serve transfer did not start a serve");

	a_restart_front: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.opcode == OP_RESTART |=> !ram_re)
		else $error("restart issued a ram read");

endmodule
